// ----- rtl/psbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbe_pkg - shared types and constants of the pulse scale blend effect
// Effect kinds, command and mode codes, register map, reset values and the
// structs that pass between the state stage and the geometry stages.
// ----------------------------------------------------------------------------
package psbe_pkg;

   // Effect kinds
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_FAIL   = 2'd2
   } kind_type;

   // Input commands
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_TRIGGER = 1'b1;

   // Trigger modes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_ACCEPT = 2'd1;
   localparam logic [1:0] MODE_FAIL   = 2'd2;

   // Register map (word index)
   localparam logic [2:0] REG_ACCEPT_RATE  = 3'd0;
   localparam logic [2:0] REG_ACCEPT_MAX   = 3'd1;
   localparam logic [2:0] REG_FAIL_RATE    = 3'd2;
   localparam logic [2:0] REG_FAIL_MAX     = 3'd3;
   localparam logic [2:0] REG_ACCEPT_COLOR = 3'd4;
   localparam logic [2:0] REG_ACCEPT_BLEND = 3'd5;
   localparam logic [2:0] REG_FAIL_COLOR   = 3'd6;
   localparam logic [2:0] REG_FAIL_BLEND   = 3'd7;

   // Reset values
   localparam logic [15:0] RATE_RESET  = 16'd256;
   localparam logic [15:0] MAX_RESET   = 16'd4096;
   localparam logic [14:0] COLOR_RESET = 15'h7fff;
   localparam logic [5:0]  BLEND_OFF   = 6'd32;

   // Configuration register set
   typedef struct packed {
      logic [15:0] accept_rate;
      logic [15:0] accept_max;
      logic [15:0] fail_rate;
      logic [15:0] fail_max;
      logic [14:0] accept_color;
      logic [5:0]  accept_blend;
      logic [14:0] fail_color;
      logic [5:0]  fail_blend;
   } cfg_type;

   // Effect state after one item
   typedef struct packed {
      kind_type    kind;
      logic [15:0] scale;
      logic [5:0]  blend;
      logic [14:0] color;
   } snap_type;

   // Base rectangle of one item
   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
   } rect_type;

   // Stage advance enables
   typedef struct packed {
      logic adv_a;
      logic adv_b;
      logic adv_c;
   } pipe_ctl_type;

   // Saturate a 22-bit signed edge to 16 bits
   function automatic logic [15:0] sat16(input logic signed [21:0] v);
      logic [15:0] r;
      if (v > 22'sd32767) begin
         r = 16'h7fff;
      end else if (v < -22'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/psbe_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbe_csr - configuration registers
// APB-style write/read port over the eight effect registers.
// ----------------------------------------------------------------------------
module psbe_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output psbe_pkg::cfg_type cfg
);

   psbe_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign idx   = paddr[4:2];
   assign wr_en = psel & penable & pwrite;

   // Decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            psbe_pkg::REG_ACCEPT_RATE:  cfg_in.accept_rate  = pwdata[15:0];
            psbe_pkg::REG_ACCEPT_MAX:   cfg_in.accept_max   = pwdata[15:0];
            psbe_pkg::REG_FAIL_RATE:    cfg_in.fail_rate    = pwdata[15:0];
            psbe_pkg::REG_FAIL_MAX:     cfg_in.fail_max     = pwdata[15:0];
            psbe_pkg::REG_ACCEPT_COLOR: cfg_in.accept_color = pwdata[14:0];
            psbe_pkg::REG_ACCEPT_BLEND: cfg_in.accept_blend = pwdata[5:0];
            psbe_pkg::REG_FAIL_COLOR:   cfg_in.fail_color   = pwdata[14:0];
            psbe_pkg::REG_FAIL_BLEND:   cfg_in.fail_blend   = pwdata[5:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accept_rate  <= psbe_pkg::RATE_RESET;
         cfg_ff.accept_max   <= psbe_pkg::MAX_RESET;
         cfg_ff.fail_rate    <= psbe_pkg::RATE_RESET;
         cfg_ff.fail_max     <= psbe_pkg::MAX_RESET;
         cfg_ff.accept_color <= psbe_pkg::COLOR_RESET;
         cfg_ff.accept_blend <= psbe_pkg::BLEND_OFF;
         cfg_ff.fail_color   <= psbe_pkg::COLOR_RESET;
         cfg_ff.fail_blend   <= psbe_pkg::BLEND_OFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         psbe_pkg::REG_ACCEPT_RATE:  prdata = {16'd0, cfg_ff.accept_rate};
         psbe_pkg::REG_ACCEPT_MAX:   prdata = {16'd0, cfg_ff.accept_max};
         psbe_pkg::REG_FAIL_RATE:    prdata = {16'd0, cfg_ff.fail_rate};
         psbe_pkg::REG_FAIL_MAX:     prdata = {16'd0, cfg_ff.fail_max};
         psbe_pkg::REG_ACCEPT_COLOR: prdata = {17'd0, cfg_ff.accept_color};
         psbe_pkg::REG_ACCEPT_BLEND: prdata = {26'd0, cfg_ff.accept_blend};
         psbe_pkg::REG_FAIL_COLOR:   prdata = {17'd0, cfg_ff.fail_color};
         psbe_pkg::REG_FAIL_BLEND:   prdata = {26'd0, cfg_ff.fail_blend};
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/psbe_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbe_state - effect state update
// Applies one tick or trigger to the effect state and captures the new
// state with the item's base rectangle into the first pipeline register.
// ----------------------------------------------------------------------------
module psbe_state (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               adv_a,
   input  logic               command,
   input  logic [1:0]         trigger_mode,
   input  psbe_pkg::rect_type rect,
   input  psbe_pkg::cfg_type  cfg,
   output psbe_pkg::snap_type snap,
   output psbe_pkg::rect_type rect_out
);

   psbe_pkg::snap_type st_ff, st_in;
   logic               growing_ff, growing_in;
   psbe_pkg::snap_type snap_ff;
   psbe_pkg::rect_type rect_ff;

   logic [15:0] rate, peak;
   logic [16:0] sum;
   logic [5:0]  blend_step;

   assign rate       = (st_ff.kind == psbe_pkg::KIND_FAIL) ? cfg.fail_rate : cfg.accept_rate;
   assign peak       = (st_ff.kind == psbe_pkg::KIND_FAIL) ? cfg.fail_max : cfg.accept_max;
   assign sum        = {1'b0, st_ff.scale} + {1'b0, rate};
   assign blend_step = (st_ff.blend < psbe_pkg::BLEND_OFF) ? st_ff.blend + 6'd1
                                                            : psbe_pkg::BLEND_OFF;

   // Next effect state
   always_comb begin
      st_in      = st_ff;
      growing_in = growing_ff;
      if (command == psbe_pkg::CMD_TRIGGER) begin
         case (trigger_mode)
            psbe_pkg::MODE_CLEAR: begin
               st_in.kind  = psbe_pkg::KIND_NONE;
               st_in.scale = 16'd0;
               st_in.blend = psbe_pkg::BLEND_OFF;
               st_in.color = psbe_pkg::COLOR_RESET;
               growing_in  = 1'b0;
            end
            psbe_pkg::MODE_ACCEPT: begin
               st_in.kind  = psbe_pkg::KIND_ACCEPT;
               st_in.scale = 16'd0;
               st_in.blend = cfg.accept_blend;
               st_in.color = cfg.accept_color;
               growing_in  = 1'b1;
            end
            psbe_pkg::MODE_FAIL: begin
               st_in.kind  = psbe_pkg::KIND_FAIL;
               st_in.scale = 16'd0;
               st_in.blend = cfg.fail_blend;
               st_in.color = cfg.fail_color;
               growing_in  = 1'b1;
            end
            default: begin
               st_in      = st_ff;
               growing_in = growing_ff;
            end
         endcase
      end else if (st_ff.kind != psbe_pkg::KIND_NONE) begin
         st_in.blend = blend_step;
         if (growing_ff) begin
            if (sum >= {1'b0, peak}) begin
               st_in.scale = peak;
               growing_in  = 1'b0;
            end else begin
               st_in.scale = sum[15:0];
            end
         end else begin
            st_in.scale = (st_ff.scale <= rate) ? 16'd0 : st_ff.scale - rate;
         end
         // end of the effect: back to idle
         if (st_in.scale == 16'd0 && blend_step == psbe_pkg::BLEND_OFF) begin
            st_in.kind  = psbe_pkg::KIND_NONE;
            st_in.blend = psbe_pkg::BLEND_OFF;
            st_in.color = psbe_pkg::COLOR_RESET;
            growing_in  = 1'b0;
         end
      end
   end

   // Persistent state advances on every accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.kind  <= psbe_pkg::KIND_NONE;
         st_ff.scale <= 16'd0;
         st_ff.blend <= psbe_pkg::BLEND_OFF;
         st_ff.color <= psbe_pkg::COLOR_RESET;
         growing_ff  <= 1'b0;
      end else if (accept) begin
         st_ff      <= st_in;
         growing_ff <= growing_in;
      end
   end

   // Stage A payload
   always_ff @(posedge clock) begin
      if (adv_a) begin
         snap_ff <= st_in;
         rect_ff <= rect;
      end
   end

   assign snap     = snap_ff;
   assign rect_out = rect_ff;

endmodule

// ----- rtl/psbe_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbe_geom - draw request geometry
// Stage B forms the rectangle size products and centers; stage C takes the
// truncated edges, the emptiness test and saturation into the result register.
// ----------------------------------------------------------------------------
module psbe_geom (
   input  logic               clock,
   input  logic               adv_b,
   input  logic               adv_c,
   input  psbe_pkg::snap_type snap,
   input  psbe_pkg::rect_type rect,
   output logic [1:0]         effect_kind_out,
   output logic               draw_valid,
   output logic [5:0]         draw_blend,
   output logic [14:0]        draw_color,
   output logic [15:0]        rect_left,
   output logic [15:0]        rect_top,
   output logic [15:0]        rect_right,
   output logic [15:0]        rect_bottom
);

   // Stage B
   logic signed [16:0] w, h, cx, cy;
   logic               pre_ok;

   logic [31:0]        pw_ff, ph_ff;
   logic signed [16:0] cx_ff, cy_ff;
   logic               ok_ff;
   logic [1:0]         kind_ff;
   logic [5:0]         blend_ff;
   logic [14:0]        color_ff;

   assign w  = $signed({rect.right[15], rect.right}) - $signed({rect.left[15], rect.left});
   assign h  = $signed({rect.bottom[15], rect.bottom}) - $signed({rect.top[15], rect.top});
   assign cx = $signed({rect.left[15], rect.left}) + $signed({2'b00, w[15:1]});
   assign cy = $signed({rect.top[15], rect.top}) + $signed({2'b00, h[15:1]});

   // visible, nonzero scale and nonempty base
   assign pre_ok = (snap.kind != psbe_pkg::KIND_NONE) && (snap.scale != 16'd0) &&
                   !snap.blend[5] && (w > 17'sd0) && (h > 17'sd0);

   always_ff @(posedge clock) begin
      if (adv_b) begin
         pw_ff    <= w[15:0] * snap.scale;
         ph_ff    <= h[15:0] * snap.scale;
         cx_ff    <= cx;
         cy_ff    <= cy;
         ok_ff    <= pre_ok;
         kind_ff  <= snap.kind;
         blend_ff <= snap.blend;
         color_ff <= snap.color;
      end
   end

   // Stage C: edge = trunc((c*8192 - w*s) / 8192)
   logic signed [33:0] num_x, num_y;
   logic signed [20:0] qx, qy, lx, ly;
   logic [19:0]        sw, sh;
   logic signed [21:0] ex_l, ey_t, ex_r, ey_b;
   logic               vis;

   assign num_x = $signed({{4{cx_ff[16]}}, cx_ff, 13'd0}) - $signed({2'b00, pw_ff});
   assign num_y = $signed({{4{cy_ff[16]}}, cy_ff, 13'd0}) - $signed({2'b00, ph_ff});
   assign qx    = num_x[33:13];
   assign qy    = num_y[33:13];
   // round toward zero for negative values with a remainder
   assign lx    = (num_x[33] && (num_x[12:0] != 13'd0)) ? qx + 21'sd1 : qx;
   assign ly    = (num_y[33] && (num_y[12:0] != 13'd0)) ? qy + 21'sd1 : qy;
   assign sw    = pw_ff[31:12];
   assign sh    = ph_ff[31:12];
   assign ex_l  = {lx[20], lx};
   assign ey_t  = {ly[20], ly};
   assign ex_r  = ex_l + $signed({2'b00, sw});
   assign ey_b  = ey_t + $signed({2'b00, sh});
   assign vis   = ok_ff && (sw != 20'd0) && (sh != 20'd0);

   logic [1:0]  kind_o_ff;
   logic        valid_o_ff;
   logic [5:0]  blend_o_ff;
   logic [14:0] color_o_ff;
   logic [15:0] l_o_ff, t_o_ff, r_o_ff, b_o_ff;

   // Result register; blend, color and edge fields are zero when nothing is drawn
   always_ff @(posedge clock) begin
      if (adv_c) begin
         kind_o_ff  <= kind_ff;
         valid_o_ff <= vis;
         blend_o_ff <= vis ? blend_ff : 6'd0;
         color_o_ff <= vis ? color_ff : 15'd0;
         l_o_ff     <= vis ? psbe_pkg::sat16(ex_l) : 16'd0;
         t_o_ff     <= vis ? psbe_pkg::sat16(ey_t) : 16'd0;
         r_o_ff     <= vis ? psbe_pkg::sat16(ex_r) : 16'd0;
         b_o_ff     <= vis ? psbe_pkg::sat16(ey_b) : 16'd0;
      end
   end

   assign effect_kind_out = kind_o_ff;
   assign draw_valid      = valid_o_ff;
   assign draw_blend      = blend_o_ff;
   assign draw_color      = color_o_ff;
   assign rect_left       = l_o_ff;
   assign rect_top        = t_o_ff;
   assign rect_right      = r_o_ff;
   assign rect_bottom     = b_o_ff;

endmodule

// ----- rtl/pulse_scale_blend_effect.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_scale_blend_effect - overlay pulse effect
// Channel  Dir  tdata                               tuser
// req      in   base_left/top/right/bottom (64 b)   command, trigger_mode
// rsp      out  blend, color, rect edges (88 b)     effect_kind_out, draw_valid
// csr      in   APB-style, eight 32-bit registers at byte address 4*i
//
// One item per cycle while rsp is not stalled; each result passes through the
// state stage, multiply stage and edge stage into the result register.
// Reset clears the effect state, the stage valids and loads register defaults.
// A stall on rsp holds the pipeline stage by stage; req_tready drops only
// when every stage is full and the result is not taken.
// ----------------------------------------------------------------------------
module pulse_scale_blend_effect (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // base_left, base_top, base_right, base_bottom
   input  logic [2:0]  req_tuser,   // command, trigger_mode[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // draw_blend, draw_color, rect_left, rect_top,
                                    // rect_right, rect_bottom, zero pad
   output logic [2:0]  rsp_tuser,   // effect_kind_out[1:0], draw_valid
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   psbe_pkg::cfg_type      cfg;
   psbe_pkg::snap_type     snap;
   psbe_pkg::rect_type     rect_in, rect_a;
   psbe_pkg::pipe_ctl_type ctl;

   logic va_ff, vb_ff, vc_ff;
   logic accept;

   // Stage advance: a stage moves when it is empty or its successor moves
   assign ctl.adv_c = !vc_ff || rsp_tready;
   assign ctl.adv_b = !vb_ff || ctl.adv_c;
   assign ctl.adv_a = !va_ff || ctl.adv_b;
   assign req_tready = ctl.adv_a;
   assign accept     = req_tvalid && ctl.adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ctl.adv_a) va_ff <= req_tvalid;
         if (ctl.adv_b) vb_ff <= va_ff;
         if (ctl.adv_c) vc_ff <= vb_ff;
      end
   end

   assign rect_in.left   = req_tdata[15:0];
   assign rect_in.top    = req_tdata[31:16];
   assign rect_in.right  = req_tdata[47:32];
   assign rect_in.bottom = req_tdata[63:48];

   psbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   psbe_state u_state (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .adv_a        (ctl.adv_a),
      .command      (req_tuser[0]),
      .trigger_mode (req_tuser[2:1]),
      .rect         (rect_in),
      .cfg          (cfg),
      .snap         (snap),
      .rect_out     (rect_a)
   );

   logic [1:0]  effect_kind_out;
   logic        draw_valid;
   logic [5:0]  draw_blend;
   logic [14:0] draw_color;
   logic [15:0] rect_left, rect_top, rect_right, rect_bottom;

   psbe_geom u_geom (
      .clock           (clock),
      .adv_b           (ctl.adv_b),
      .adv_c           (ctl.adv_c),
      .snap            (snap),
      .rect            (rect_a),
      .effect_kind_out (effect_kind_out),
      .draw_valid      (draw_valid),
      .draw_blend      (draw_blend),
      .draw_color      (draw_color),
      .rect_left       (rect_left),
      .rect_top        (rect_top),
      .rect_right      (rect_right),
      .rect_bottom     (rect_bottom)
   );

   assign rsp_tvalid = vc_ff;
   assign rsp_tuser  = {draw_valid, effect_kind_out};
   assign rsp_tdata  = {3'd0, rect_bottom, rect_right, rect_top, rect_left,
                        draw_color, draw_blend};

endmodule
